### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the pyramid reducer.
// Needs signals named clock and reset in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while reset is low.
`define ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: same-cycle implication failed");

// Next-cycle implication, checked while reset is low.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: next-cycle implication failed");

`endif

### rtl/ihpr_pkg.sv
// Package for the pyramid reducer: register indexes, reset values, mode
// codes, the queue geometry and the control struct. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ihpr_pkg;

   // Configuration register indexes.
   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_REDUCE_MODE  = 2'd2;

   localparam int IMAGE_WIDTH_BITS  = 13;
   localparam int IMAGE_HEIGHT_BITS = 16;
   localparam int CSR_DATA_BITS     = 16;
   localparam int FIELD_BITS        = 16;

   localparam logic [12:0] IMAGE_WIDTH_RESET  = 13'd640;
   localparam logic [15:0] IMAGE_HEIGHT_RESET = 16'd480;

   typedef enum logic [1:0] {
      MODE_BINOMIAL = 2'd0,
      MODE_DECIMATE = 2'd1,
      MODE_AVERAGE  = 2'd2
   } mode_type;

   // Queue between the front and back parts.
   localparam int QUEUE_AW    = 1;
   localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

   // Classification of one item, made by the front part.
   typedef struct packed {
      logic     emit;        // item completes a 2x2 block and yields a result
      logic     top_clamp;   // block sits on the first input row pair
      logic     left_clamp;  // block sits on the first input column pair
      logic     last;        // result is the last one of the image
      mode_type mode;
   } ctl_type;

endpackage

`default_nettype wire

### rtl/ihpr_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ihpr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/ihpr_front.sv
// Front part of the pyramid reducer: configuration registers, raster
// counters, item classification and the line buffer. Uses ihpr_pkg, ihpr_ram.
`timescale 1ns / 1ps
`default_nettype none

module ihpr_front #(
   parameter int MAX_WIDTH  = 4096,
   parameter int PIXEL_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_wr_en,
   input  wire logic [1:0]              csr_index,
   input  wire logic [15:0]             csr_wr_data,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [15:0]             req_tdata,
   input  wire logic                    q_full,
   output logic                         push,
   output logic [3*PIXEL_BITS-1:0]      push_data,   // {pixel, row r-1, row r-2}
   output ihpr_pkg::ctl_type            push_ctl
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int EW = $clog2(MAX_WIDTH + 1);
   localparam int WW = (EW > ihpr_pkg::IMAGE_WIDTH_BITS) ? EW : ihpr_pkg::IMAGE_WIDTH_BITS;
   localparam int PB = PIXEL_BITS;

   // Configuration.
   logic [12:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [1:0]  mode_ff, mode_in;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      mode_in   = mode_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            ihpr_pkg::REG_IMAGE_WIDTH:  width_in  = csr_wr_data[12:0];
            ihpr_pkg::REG_IMAGE_HEIGHT: height_in = csr_wr_data;
            ihpr_pkg::REG_REDUCE_MODE:  mode_in   = csr_wr_data[1:0];
            default: ;
         endcase
      end
   end

   // Effective geometry after clamping.
   logic [WW-1:0] width_ext, eff_w, last_c;
   logic [15:0]   eff_h, last_r;

   assign width_ext = WW'(width_ff);

   always_comb begin
      if (width_ext < WW'(2)) begin
         eff_w = WW'(2);
      end else if (width_ext > WW'(MAX_WIDTH)) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = width_ext;
      end
   end

   assign eff_h  = (height_ff < 16'd2) ? 16'd2 : height_ff;
   assign last_c = {eff_w[WW-1:1], 1'b0} - WW'(1);
   assign last_r = {eff_h[15:1], 1'b0} - 16'd1;

   // Raster position.
   logic [AW-1:0] col_ff, col_in, col_cur;
   logic [15:0]   row_ff, row_in, row_cur;
   logic          col_wrap, row_wrap, accept;

   assign col_cur  = (WW'(col_ff) >= eff_w) ? '0 : col_ff;
   assign row_cur  = (row_ff >= eff_h) ? 16'd0 : row_ff;
   assign col_wrap = (WW'(col_cur) + WW'(1)) >= eff_w;
   assign row_wrap = ({1'b0, row_cur} + 17'd1) >= {1'b0, eff_h};

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? 16'd0 : row_cur + 16'd1;
         end else begin
            col_in = col_cur + AW'(1);
            row_in = row_cur;
         end
      end
   end

   // Classification.
   ihpr_pkg::ctl_type ctl_cur;

   always_comb begin
      ctl_cur.emit       = col_cur[0] & row_cur[0];
      ctl_cur.top_clamp  = (row_cur == 16'd1);
      ctl_cur.left_clamp = (col_cur == AW'(1));
      ctl_cur.last       = (row_cur == last_r) && (WW'(col_cur) == last_c);
      unique case (mode_ff)
         ihpr_pkg::MODE_DECIMATE: ctl_cur.mode = ihpr_pkg::MODE_DECIMATE;
         ihpr_pkg::MODE_AVERAGE:  ctl_cur.mode = ihpr_pkg::MODE_AVERAGE;
         default:                 ctl_cur.mode = ihpr_pkg::MODE_BINOMIAL;
      endcase
   end

   // Line buffer: each entry holds {row r-1, row r-2} for one column.
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [2*PB-1:0]   wr_data, ram_rd_data, entry;

   // Stage register between the read and the write-back of the line buffer.
   logic              s1_valid_ff, s1_valid_in;
   logic [PB-1:0]     s1_px_ff;
   logic [AW-1:0]     s1_addr_ff;
   ihpr_pkg::ctl_type s1_ctl_ff;
   logic              s1_byp_ff;
   logic [2*PB-1:0]   s1_byp_data_ff;
   logic [PB-1:0]     a1, a2;

   assign rd_addr = col_cur & AW'(MAX_WIDTH - 1);

   assign req_tready = !s1_valid_ff || !q_full;
   assign accept     = req_tvalid && req_tready;
   assign push       = s1_valid_ff && !q_full;

   assign entry   = s1_byp_ff ? s1_byp_data_ff : ram_rd_data;
   assign a1      = entry[2*PB-1:PB];
   assign a2      = entry[PB-1:0];
   assign wr_en   = push;
   assign wr_addr = s1_addr_ff;
   assign wr_data = {s1_px_ff, a1};

   assign s1_valid_in = accept ? 1'b1 : (push ? 1'b0 : s1_valid_ff);

   ihpr_ram #(
      .WIDTH (2 * PB),
      .DEPTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= ihpr_pkg::IMAGE_WIDTH_RESET;
         height_ff   <= ihpr_pkg::IMAGE_HEIGHT_RESET;
         mode_ff     <= 2'(ihpr_pkg::MODE_BINOMIAL);
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         mode_ff     <= mode_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_px_ff       <= req_tdata[PB-1:0];
         s1_addr_ff     <= col_cur;
         s1_ctl_ff      <= ctl_cur;
         // A write to the address being read in this cycle is forwarded.
         s1_byp_ff      <= wr_en && (wr_addr == rd_addr);
         s1_byp_data_ff <= wr_data;
      end
   end

   assign push_data = {s1_px_ff, a1, a2};
   assign push_ctl  = s1_ctl_ff;

endmodule

`default_nettype wire

### rtl/ihpr_queue.sv
// Short queue of classified items between the front and back parts.
// Uses ihpr_pkg for the control struct and queue geometry.
`timescale 1ns / 1ps
`default_nettype none

module ihpr_queue #(
   parameter int DATA_W = 48
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   input  ihpr_pkg::ctl_type      push_ctl,
   input  wire logic              pop,
   output logic [DATA_W-1:0]      pop_data,
   output ihpr_pkg::ctl_type      pop_ctl,
   output logic                   full,
   output logic                   empty
);

   localparam int AW = ihpr_pkg::QUEUE_AW;
   localparam int DEPTH = ihpr_pkg::QUEUE_DEPTH;

   logic [DATA_W-1:0]  data_ff [DEPTH];
   logic [DATA_W-1:0]  data_in [DEPTH];
   ihpr_pkg::ctl_type  ctl_ff  [DEPTH];
   ihpr_pkg::ctl_type  ctl_in  [DEPTH];
   logic [AW-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AW:0]        count_ff, count_in;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         data_in[i] = data_ff[i];
         ctl_in[i]  = ctl_ff[i];
         if (push && (wr_ptr_ff == AW'(i))) begin
            data_in[i] = push_data;
            ctl_in[i]  = push_ctl;
         end
      end
   end

   assign wr_ptr_in = push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
   assign rd_ptr_in = pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (AW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      data_ff <= data_in;
      ctl_ff  <= ctl_in;
   end

   assign pop_data = data_ff[rd_ptr_ff];
   assign pop_ctl  = ctl_ff[rd_ptr_ff];
   assign full     = (count_ff == (AW+1)'(DEPTH));
   assign empty    = (count_ff == '0);

endmodule

`default_nettype wire

### rtl/ihpr_back.sv
// Back part of the pyramid reducer: 3x2 window, filter arithmetic in stages A
// and B, and the output register. Uses ihpr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ihpr_back #(
   parameter int PIXEL_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      q_empty,
   input  wire logic [3*PIXEL_BITS-1:0]   pop_data,   // {pixel, row r-1, row r-2}
   input  ihpr_pkg::ctl_type              pop_ctl,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [15:0]                    rsp_tdata,
   output logic                           rsp_tlast
);

   localparam int PB = PIXEL_BITS;
   localparam int SW = PB + 2;   // three-tap row sum, four-pixel sum
   localparam int TW = PB + 4;   // full 3x3 weighted sum

   logic advance;

   // Window: 0..2 hold rows r-2, r-1, r at column c-1; 3..5 at column c-2.
   logic [PB-1:0] win_ff [6];
   logic [PB-1:0] win_in [6];

   logic [PB-1:0] px, a1, a2;
   logic [PB-1:0] m_t, m_m, m_b, l_t, l_m, l_b, r_t, r_m, r_b;

   assign px = pop_data[3*PB-1:2*PB];
   assign a1 = pop_data[2*PB-1:PB];
   assign a2 = pop_data[PB-1:0];

   assign advance = !rsp_tvalid || rsp_tready;
   assign pop     = advance && !q_empty;

   always_comb begin
      m_t = pop_ctl.top_clamp ? win_ff[1] : win_ff[0];
      m_m = win_ff[1];
      m_b = win_ff[2];
      l_t = pop_ctl.left_clamp ? m_t : (pop_ctl.top_clamp ? win_ff[4] : win_ff[3]);
      l_m = pop_ctl.left_clamp ? m_m : win_ff[4];
      l_b = pop_ctl.left_clamp ? m_b : win_ff[5];
      r_t = pop_ctl.top_clamp ? a1 : a2;
      r_m = a1;
      r_b = px;
   end

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         win_in[i] = win_ff[i];
      end
      if (pop) begin
         win_in[3] = win_ff[0];
         win_in[4] = win_ff[1];
         win_in[5] = win_ff[2];
         win_in[0] = a2;
         win_in[1] = a1;
         win_in[2] = px;
      end
   end

   // Stage A: row sums of the 1-2-1 kernel, the 2x2 sum and the decimated pixel.
   logic              sa_valid_ff, sa_valid_in;
   logic [SW-1:0]     sum_t_ff, sum_m_ff, sum_b_ff, avg_ff;
   logic [PB-1:0]     mid_ff;
   logic              sa_last_ff;
   ihpr_pkg::mode_type sa_mode_ff;

   assign sa_valid_in = advance ? (pop && pop_ctl.emit) : sa_valid_ff;

   // Stage B: final weighting, truncating divide and mode select.
   logic [TW-1:0]  total;
   logic [PB-1:0]  result;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [15:0]    rsp_data_ff;
   logic           rsp_last_ff;

   assign total = TW'(sum_t_ff) + (TW'(sum_m_ff) << 1) + TW'(sum_b_ff);

   always_comb begin
      unique case (sa_mode_ff)
         ihpr_pkg::MODE_DECIMATE: result = mid_ff;
         ihpr_pkg::MODE_AVERAGE:  result = avg_ff[SW-1:2];
         ihpr_pkg::MODE_BINOMIAL: result = total[TW-1:4];
         default:                 result = total[TW-1:4];
      endcase
   end

   assign rsp_valid_in = advance ? sa_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
         sa_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_ff       <= win_in;
         sa_valid_ff  <= sa_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         sum_t_ff    <= SW'(l_t) + (SW'(m_t) << 1) + SW'(r_t);
         sum_m_ff    <= SW'(l_m) + (SW'(m_m) << 1) + SW'(r_m);
         sum_b_ff    <= SW'(l_b) + (SW'(m_b) << 1) + SW'(r_b);
         avg_ff      <= SW'(m_m) + SW'(r_m) + SW'(m_b) + SW'(r_b);
         mid_ff      <= m_m;
         sa_last_ff  <= pop_ctl.last;
         sa_mode_ff  <= pop_ctl.mode;
         rsp_data_ff <= 16'(result);
         rsp_last_ff <= sa_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

### rtl/image_halving_pyramid_reduce.sv
// Pyramid reducer by two: takes an image in raster order on req_ and emits
// the half-width, half-height image on rsp_. Uses every ihpr_* module.
//
// Usage. Input pixels arrive on req_tdata, one item per accepted handshake,
// in raster order of an image of image_width by image_height pixels. Result
// items leave on rsp_tdata, with rsp_tlast set on the last result of each
// image. An odd last row or column produces no results. The csr_ port sets
// width, height and mode; each write lands at the clock edge where
// csr_wr_en is high and takes effect for the next pixel. Raster counters
// keep their place across writes.
// Throughput: one pixel per cycle, sustained, in every mode, while the output is not stalled.
// Path: a 2x2 block's result passes the line buffer read stage, the queue,
// arithmetic stages A and B and the output register that drives rsp_tvalid.
// Reset: clears the counters, the window and all valid bits, and restores
// width 640, height 480 and the binomial mode. The line buffer is not
// cleared; no result depends on an entry before it was written.
// Stall: while rsp_tvalid is high and rsp_tready low, the output and arithmetic stages
// hold, the two-entry queue fills, and req_tready drops only once the queue is full.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module image_halving_pyramid_reduce #(
   parameter int MAX_WIDTH  = 4096,
   parameter int PIXEL_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Configuration write port.
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wr_data,
   // Input pixels.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,    // [15:0] pixel
   // Reduced pixels.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,    // [15:0] out_pixel
   output logic             rsp_tlast     // end_of_image
);

   localparam int DATA_W = 3 * PIXEL_BITS;

   logic              push, pop, q_full, q_empty;
   logic [DATA_W-1:0] push_data, pop_data;
   ihpr_pkg::ctl_type push_ctl, pop_ctl;

   // Front: registers, counters, classification and line buffer.
   ihpr_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .q_full      (q_full),
      .push        (push),
      .push_data   (push_data),
      .push_ctl    (push_ctl)
   );

   // The queue lets the front keep accepting while the output is stalled.
   ihpr_queue #(
      .DATA_W (DATA_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .push_ctl  (push_ctl),
      .pop       (pop),
      .pop_data  (pop_data),
      .pop_ctl   (pop_ctl),
      .full      (q_full),
      .empty     (q_empty)
   );

   // Back: window, filter arithmetic and output register.
   ihpr_back #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .pop_data   (pop_data),
      .pop_ctl    (pop_ctl),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // The front never pushes into a full queue and the back never pops an
   // empty one; an accepted pixel is pending in the front on the next cycle.
   `ASSERT_IMPLIES(a_push_not_full, push, !q_full)
   `ASSERT_IMPLIES(a_pop_not_empty, pop, !q_empty)
   `ASSERT_NEXT(a_accept_pending, req_tvalid && req_tready, push || q_full)

endmodule

`default_nettype wire
